// ===== hdl/som_best_matching_unit_top_assert.svh =====
// assertion macros used by the best matching unit engine
`ifndef SOM_BEST_MATCHING_UNIT_TOP_ASSERT_SVH
`define SOM_BEST_MATCHING_UNIT_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SBMU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define SBMU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sbmu_pkg.sv =====
// shared types and constants of the best matching unit search
`timescale 1ns / 1ps

package sbmu_pkg;

   // element and distance widths
   localparam int ELEM_BITS   = 16;
   localparam int DIFF_W      = ELEM_BITS + 1;
   localparam int SQ_W        = 2 * ELEM_BITS;
   localparam int DIM_CNT_W   = 5;
   localparam int CELL_CNT_W  = 7;
   localparam int DIST_W      = SQ_W + DIM_CNT_W;
   localparam int CELL_IDX_W  = 6;
   localparam int DIM_IDX_W   = 4;
   localparam int LABEL_W     = 6;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes (paddr bit 2)
   localparam logic REG_CELLS = 1'b0;
   localparam logic REG_DIMS  = 1'b1;

   typedef logic [CELL_CNT_W-1:0]       cell_cnt_type;
   typedef logic [DIM_CNT_W-1:0]        dim_cnt_type;
   typedef logic [DIST_W-1:0]           dist_type;
   typedef logic signed [ELEM_BITS-1:0] elem_type;

   // classified work item
   typedef struct packed {
      logic                  wr_proto;
      logic                  wr_query;
      logic                  search;
      logic [CELL_IDX_W-1:0] cell_index;
      logic [DIM_IDX_W-1:0]  dim_index;
      elem_type              elem_value;
   } cmd_type;

   // tag that travels with each multiply-add
   typedef struct packed {
      logic         valid;
      logic         first;
      logic         last_dim;
      logic         last_all;
      cell_cnt_type cell_idx;
   } tag_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

// ===== hdl/sbmu_front.sv =====
// front end: accepts request beats and turns them into queue commands
`timescale 1ns / 1ps

module sbmu_front #(
   parameter int MAP_CELLS   = 64,
   parameter int VECTOR_DIMS = 16
) (
   input  logic                                req_valid,
   input  logic                                req_kind,
   input  logic [sbmu_pkg::CELL_IDX_W-1:0]     req_cell,
   input  logic [sbmu_pkg::DIM_IDX_W-1:0]      req_dim,
   input  sbmu_pkg::elem_type                  req_value,
   input  logic                                req_last,
   input  logic                                queue_full,
   output logic                                req_ready,
   output logic                                push,
   output sbmu_pkg::cmd_type                   cmd
);

   logic is_query;
   logic cell_ok;
   logic dim_ok;

   // range checks against the stored geometry
   assign is_query = (req_kind == sbmu_pkg::REQ_QUERY);
   assign cell_ok  = (32'(req_cell) < MAP_CELLS);
   assign dim_ok   = (32'(req_dim) < VECTOR_DIMS);

   // classify the beat
   always_comb begin
      cmd.wr_proto   = !is_query && cell_ok && dim_ok;
      cmd.wr_query   = is_query && dim_ok;
      cmd.search     = is_query && req_last;
      cmd.cell_index = req_cell;
      cmd.dim_index  = req_dim;
      cmd.elem_value = req_value;
   end

   // beats that change nothing are taken and dropped
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready && (cmd.wr_proto || cmd.wr_query || cmd.search);

endmodule

// ===== hdl/sbmu_fifo.sv =====
// short command queue between front end and search engine
`timescale 1ns / 1ps

module sbmu_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbmu_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output sbmu_pkg::cmd_type head_cmd
);

   sbmu_pkg::cmd_type                entry_ff [sbmu_pkg::QUEUE_DEPTH];
   logic [sbmu_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sbmu_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sbmu_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full      = (count_ff == sbmu_pkg::QCNT_W'(sbmu_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/sbmu_engine.sv =====
// back end: prototype and query memories, distance pipeline, result register
`timescale 1ns / 1ps
`include "som_best_matching_unit_top_assert.svh"

module sbmu_engine #(
   parameter int MAP_CELLS   = 64,
   parameter int VECTOR_DIMS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  sbmu_pkg::cmd_type                cmd,
   output logic                             pop,
   input  sbmu_pkg::cell_cnt_type           cfg_cells,
   input  sbmu_pkg::dim_cnt_type            cfg_dims,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sbmu_pkg::LABEL_W-1:0]     rsp_label,
   output logic                             rsp_found
);

   localparam int DEPTH = MAP_CELLS * VECTOR_DIMS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QAW   = (VECTOR_DIMS > 1) ? $clog2(VECTOR_DIMS) : 1;

   sbmu_pkg::elem_type proto_mem [DEPTH];
   sbmu_pkg::elem_type query_mem [VECTOR_DIMS];

   sbmu_pkg::state_type     state_ff, state_in;
   sbmu_pkg::cell_cnt_type  cell_ff, cell_in;
   sbmu_pkg::dim_cnt_type   dim_ff, dim_in;
   sbmu_pkg::cell_cnt_type  ncells_ff, ncells_in;
   sbmu_pkg::dim_cnt_type   ndims_ff, ndims_in;
   sbmu_pkg::cell_cnt_type  ncells_now;
   sbmu_pkg::dim_cnt_type   ndims_now;

   sbmu_pkg::tag_type       tag1_ff, tag1_in, tag2_ff, tag3_ff, tag4_ff;
   sbmu_pkg::elem_type      p_rd_ff, q_rd_ff;
   logic signed [sbmu_pkg::DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [2*sbmu_pkg::DIFF_W-1:0] prod;
   logic [sbmu_pkg::SQ_W-1:0]            sq_ff;
   sbmu_pkg::dist_type      acc_ff, acc_in;
   sbmu_pkg::dist_type      best_ff;
   sbmu_pkg::cell_cnt_type  best_cell_ff;
   logic                    have_ff;
   logic                    better;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [sbmu_pkg::LABEL_W-1:0] label_ff, label_in;
   logic                    found_ff, found_in;

   logic                    issue;
   logic                    last_dim;
   logic                    last_cell;
   logic                    start;
   logic                    degenerate;
   logic [31:0]             wr_addr_wide;
   logic [31:0]             rd_addr_wide;
   logic [31:0]             qwr_addr_wide;
   logic [31:0]             qrd_addr_wide;

   // clamp the configured geometry to the stored one
   assign ncells_now = (32'(cfg_cells) > MAP_CELLS) ?
                       sbmu_pkg::cell_cnt_type'(MAP_CELLS) : cfg_cells;
   assign ndims_now  = (32'(cfg_dims) > VECTOR_DIMS) ?
                       sbmu_pkg::dim_cnt_type'(VECTOR_DIMS) : cfg_dims;

   // a search waits until the result register is free
   assign pop = cmd_valid && (state_ff == sbmu_pkg::ST_IDLE) && (!cmd.search || !rsp_valid_ff);
   assign start      = pop && cmd.search;
   assign degenerate = (ncells_now == '0) || (ndims_now == '0);

   // memory addresses
   assign wr_addr_wide  = 32'(cmd.cell_index) * 32'(VECTOR_DIMS) + 32'(cmd.dim_index);
   assign rd_addr_wide  = 32'(cell_ff) * 32'(VECTOR_DIMS) + 32'(dim_ff);
   assign qwr_addr_wide = 32'(cmd.dim_index);
   assign qrd_addr_wide = 32'(dim_ff);

   // sweep position
   assign issue     = (state_ff == sbmu_pkg::ST_RUN);
   assign last_dim  = (dim_ff == ndims_ff - 1'b1);
   assign last_cell = (cell_ff == ncells_ff - 1'b1);

   always_comb begin
      tag1_in.valid    = issue;
      tag1_in.first    = (dim_ff == '0);
      tag1_in.last_dim = last_dim;
      tag1_in.last_all = last_dim && last_cell;
      tag1_in.cell_idx = cell_ff;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cell_in   = cell_ff;
      dim_in    = dim_ff;
      ncells_in = ncells_ff;
      ndims_in  = ndims_ff;
      case (state_ff)
         sbmu_pkg::ST_IDLE: begin
            if (start && !degenerate) begin
               state_in  = sbmu_pkg::ST_RUN;
               cell_in   = '0;
               dim_in    = '0;
               ncells_in = ncells_now;
               ndims_in  = ndims_now;
            end
         end
         sbmu_pkg::ST_RUN: begin
            if (last_dim) begin
               dim_in  = '0;
               cell_in = cell_ff + 1'b1;
               if (last_cell) begin
                  state_in = sbmu_pkg::ST_DRAIN;
               end
            end else begin
               dim_in = dim_ff + 1'b1;
            end
         end
         sbmu_pkg::ST_DRAIN: begin
            if (tag4_ff.valid && tag4_ff.last_all) begin
               state_in = sbmu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbmu_pkg::ST_IDLE;
         end
      endcase
   end

   // memories: writes from the queue, registered reads for the sweep
   always_ff @(posedge clock) begin
      if (pop && cmd.wr_proto) begin
         proto_mem[wr_addr_wide[AW-1:0]] <= cmd.elem_value;
      end
      if (pop && cmd.wr_query) begin
         query_mem[qwr_addr_wide[QAW-1:0]] <= cmd.elem_value;
      end
      if (issue) begin
         p_rd_ff <= proto_mem[rd_addr_wide[AW-1:0]];
         q_rd_ff <= query_mem[qrd_addr_wide[QAW-1:0]];
      end
   end

   // difference, square and accumulate
   assign diff_in = sbmu_pkg::DIFF_W'(q_rd_ff) - sbmu_pkg::DIFF_W'(p_rd_ff);
   assign prod    = diff_ff * diff_ff;
   assign acc_in  = tag3_ff.first ? sbmu_pkg::DIST_W'(sq_ff)
                                  : acc_ff + sbmu_pkg::DIST_W'(sq_ff);

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= prod[sbmu_pkg::SQ_W-1:0];
      acc_ff  <= acc_in;
   end

   // compare finished distances, lowest cell wins ties
   assign better = !have_ff || (acc_ff < best_ff);

   always_ff @(posedge clock) begin
      if (tag4_ff.valid && tag4_ff.last_dim && better) begin
         best_ff      <= acc_ff;
         best_cell_ff <= tag4_ff.cell_idx;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      label_in     = label_ff;
      found_in     = found_ff;
      if (start && degenerate) begin
         rsp_valid_in = 1'b1;
         label_in     = '0;
         found_in     = (ncells_now != '0);
      end else if (tag4_ff.valid && tag4_ff.last_all) begin
         rsp_valid_in = 1'b1;
         label_in     = better ? tag4_ff.cell_idx[sbmu_pkg::LABEL_W-1:0]
                               : best_cell_ff[sbmu_pkg::LABEL_W-1:0];
         found_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      label_ff <= label_in;
      found_ff <= found_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbmu_pkg::ST_IDLE;
         cell_ff      <= '0;
         dim_ff       <= '0;
         ncells_ff    <= '0;
         ndims_ff     <= '0;
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         tag4_ff      <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cell_ff      <= cell_in;
         dim_ff       <= dim_in;
         ncells_ff    <= ncells_in;
         ndims_ff     <= ndims_in;
         tag1_ff      <= tag1_in;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         tag4_ff      <= tag3_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (start) begin
            have_ff <= 1'b0;
         end else if (tag4_ff.valid && tag4_ff.last_dim) begin
            have_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_label = label_ff;
   assign rsp_found = found_ff;

   // checks
   `SBMU_ASSERT_IMPLY(a_start_rsp_free, clock, reset, start, !rsp_valid_ff,
      "search started while a result is pending")
   `SBMU_ASSERT_IMPLY(a_last_in_drain, clock, reset, tag4_ff.valid && tag4_ff.last_all,
      state_ff == sbmu_pkg::ST_DRAIN, "final distance outside drain")
   `SBMU_ASSERT_NEXT(a_rsp_after_last, clock, reset, tag4_ff.valid && tag4_ff.last_all,
      rsp_valid_ff, "no result after final distance")
   `SBMU_ASSERT_IMPLY(a_sweep_in_range, clock, reset, state_ff == sbmu_pkg::ST_RUN,
      (cell_ff < ncells_ff) && (dim_ff < ndims_ff), "sweep position out of range")

endmodule

// ===== hdl/som_best_matching_unit_top.sv =====
// top level of the self-organizing map best matching unit search
//
// req channel: one beat per element. tuser[0] picks a prototype load (0) or a
// query element (1); tlast on a query element starts the search over the map.
// rsp channel: one beat per query element with tlast, carrying the closest
// cell (lowest index on ties) and a found flag.
// csr port: cells_in_use at 0x0, dims_in_use at 0x4; the user must write them only
// while idle, the block does not enforce it. Beats pass through a four-entry
// command queue to the search engine, which writes a load or plain query element
// to its memory as it pops it. A search streams the prototype memory through one
// subtract / square / accumulate unit, one element per cycle, via the read,
// difference, square, accumulate and result registers before rsp_tvalid rises.
// The queue keeps taking beats during a search until it fills; a pending
// result holds rsp_tdata until rsp_tready, and the next search waits for it.
// Reset clears the queue, the sequencer and the result register and sets the
// registers to 64 cells and 16 dims; prototype and query memories keep
// their contents and must be written before use.
`timescale 1ns / 1ps

module som_best_matching_unit_top #(
   parameter int MAP_CELLS   = 64,
   parameter int VECTOR_DIMS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // cell_index[5:0], dim_index[9:6], elem_value[25:10]
   input  logic [0:0]  req_tuser,   // req_type[0]
   input  logic        req_tlast,
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // label[5:0]
   output logic [0:0]  rsp_tuser,   // found[0]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   sbmu_pkg::cell_cnt_type        cells_ff, cells_in;
   sbmu_pkg::dim_cnt_type         dims_ff, dims_in;
   logic                          csr_wr;

   logic                          push;
   logic                          pop;
   logic                          queue_full;
   logic                          queue_valid;
   sbmu_pkg::cmd_type             push_cmd;
   sbmu_pkg::cmd_type             head_cmd;
   logic [sbmu_pkg::LABEL_W-1:0]  label;
   logic                          found;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cells_in = cells_ff;
      dims_in  = dims_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            sbmu_pkg::REG_CELLS: cells_in = csr_pwdata[sbmu_pkg::CELL_CNT_W-1:0];
            sbmu_pkg::REG_DIMS:  dims_in  = csr_pwdata[sbmu_pkg::DIM_CNT_W-1:0];
            default: begin
               cells_in = cells_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= sbmu_pkg::cell_cnt_type'(64);
         dims_ff  <= sbmu_pkg::dim_cnt_type'(16);
      end else begin
         cells_ff <= cells_in;
         dims_ff  <= dims_in;
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr[2])
         sbmu_pkg::REG_CELLS: csr_prdata = 32'(cells_ff);
         sbmu_pkg::REG_DIMS:  csr_prdata = 32'(dims_ff);
         default:             csr_prdata = '0;
      endcase
   end

   sbmu_front #(
      .MAP_CELLS   (MAP_CELLS),
      .VECTOR_DIMS (VECTOR_DIMS)
   ) u_front (
      .req_valid  (req_tvalid),
      .req_kind   (req_tuser[0]),
      .req_cell   (req_tdata[5:0]),
      .req_dim    (req_tdata[9:6]),
      .req_value  (req_tdata[25:10]),
      .req_last   (req_tlast),
      .queue_full (queue_full),
      .req_ready  (req_tready),
      .push       (push),
      .cmd        (push_cmd)
   );

   sbmu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .head_cmd  (head_cmd)
   );

   sbmu_engine #(
      .MAP_CELLS   (MAP_CELLS),
      .VECTOR_DIMS (VECTOR_DIMS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (head_cmd),
      .pop       (pop),
      .cfg_cells (cells_ff),
      .cfg_dims  (dims_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_label (label),
      .rsp_found (found)
   );

   // result beat packing
   assign rsp_tdata = 8'(label);
   assign rsp_tuser = found;

endmodule

// ===== tb/sv/tb_som_best_matching_unit_top.sv =====
// self-checking testbench of the best matching unit search top level
`timescale 1ns / 1ps

module tb_som_best_matching_unit_top;

   localparam int MAP_CELLS     = 64;
   localparam int VECTOR_DIMS   = 16;
   localparam int STALL_LIMIT   = 10000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 16;
   localparam int RANDOM_ITEMS  = 200;

   typedef struct packed {
      logic                         found;
      logic [sbmu_pkg::LABEL_W-1:0] label;
   } bmu_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // cell_index[5:0], dim_index[9:6], elem_value[25:10]
   logic [0:0]  req_tuser   = '0;   // req_type[0]
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // label[5:0]
   logic [0:0]  rsp_tuser;          // found[0]
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow of the map, the query and the registers
   sbmu_pkg::elem_type     proto_mem [MAP_CELLS][VECTOR_DIMS];
   sbmu_pkg::elem_type     query_mem [VECTOR_DIMS];
   sbmu_pkg::cell_cnt_type cells_reg = 7'd64;
   sbmu_pkg::dim_cnt_type  dims_reg  = 5'd16;

   bmu_result_type pending_matches [$];
   int             mismatch_count = 0;
   int             items_sent     = 0;
   int             rsp_hold_left  = 0;
   bit             req_steady     = 1'b0;
   bit             rsp_steady     = 1'b0;

   som_best_matching_unit_top #(
      .MAP_CELLS   (MAP_CELLS),
      .VECTOR_DIMS (VECTOR_DIMS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact squared distance search over the cells and dims in use
   function automatic bmu_result_type nearest_cell();
      int             ncells;
      int             ndims;
      int             c;
      int             d;
      longint         diff;
      longint         cell_dist;
      longint         best_dist;
      bmu_result_type m;
      ncells = (cells_reg > MAP_CELLS) ? MAP_CELLS : cells_reg;
      ndims  = (dims_reg > VECTOR_DIMS) ? VECTOR_DIMS : dims_reg;
      m = '0;
      best_dist = 0;
      for (c = 0; c < ncells; c++) begin
         cell_dist = 0;
         for (d = 0; d < ndims; d++) begin
            diff = longint'(query_mem[d]) - longint'(proto_mem[c][d]);
            cell_dist += diff * diff;
         end
         if (!m.found || cell_dist < best_dist) begin
            m.found = 1'b1;
            m.label = c[sbmu_pkg::LABEL_W-1:0];
            best_dist = cell_dist;
         end
      end
      return m;
   endfunction

   // element value biased toward the extremes, zero and minus one
   function automatic sbmu_pkg::elem_type pick_elem();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return sbmu_pkg::elem_type'($urandom);
      endcase
   endfunction

   // one request beat, then update the shadow and the expected results
   task automatic send_elem(input logic kind,
                            input logic [sbmu_pkg::CELL_IDX_W-1:0] cell_idx,
                            input logic [sbmu_pkg::DIM_IDX_W-1:0] dim,
                            input sbmu_pkg::elem_type value,
                            input logic last);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last;
      req_tdata  <= {6'b0, value, dim, cell_idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (kind == sbmu_pkg::REQ_LOAD) begin
         proto_mem[cell_idx][dim] = value;
      end else begin
         query_mem[dim] = value;
         if (last) pending_matches.push_back(nearest_cell());
      end
   endtask

   // whole query vector, often a near copy of a stored prototype
   task automatic send_query_vector();
      int                 ndims;
      int                 src;
      int                 d;
      sbmu_pkg::elem_type v;
      ndims = (dims_reg > VECTOR_DIMS) ? VECTOR_DIMS : dims_reg;
      src = ($urandom_range(0, 2) == 0) ? $urandom_range(0, cells_reg - 1) : -1;
      for (d = 0; d < ndims; d++) begin
         if (src < 0)
            v = pick_elem();
         else if ($urandom_range(0, 3) == 0)
            v = proto_mem[src][d] + sbmu_pkg::elem_type'($urandom_range(0, 4) - 2);
         else
            v = proto_mem[src][d];
         send_elem(sbmu_pkg::REQ_QUERY, sbmu_pkg::CELL_IDX_W'($urandom_range(0, 63)),
                   sbmu_pkg::DIM_IDX_W'(d), v, d == ndims - 1);
      end
   endtask

   // wait until every search has answered and the queue has emptied
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup phase, then access phase, then the bus goes idle
   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == sbmu_pkg::REG_CELLS)
         cells_reg = value[sbmu_pkg::CELL_CNT_W-1:0];
      else
         dims_reg = value[sbmu_pkg::DIM_CNT_W-1:0];
      @(posedge clock);
   endtask

   task automatic set_map_size(input int cells, input int dims);
      drain_results();
      csr_write(sbmu_pkg::REG_CELLS, cells);
      csr_write(sbmu_pkg::REG_DIMS, dims);
   endtask

   // write every prototype element and the query, then search at reset sizes
   task automatic test_fill_map();
      int c;
      int d;
      for (c = 0; c < MAP_CELLS; c++)
         for (d = 0; d < VECTOR_DIMS; d++)
            send_elem(sbmu_pkg::REQ_LOAD, sbmu_pkg::CELL_IDX_W'(c),
                      sbmu_pkg::DIM_IDX_W'(d), pick_elem(), $urandom_range(0, 7) == 0);
      for (d = 0; d < VECTOR_DIMS; d++)
         send_elem(sbmu_pkg::REQ_QUERY, sbmu_pkg::CELL_IDX_W'($urandom_range(0, 63)),
                   sbmu_pkg::DIM_IDX_W'(d), pick_elem(), 1'b0);
      send_query_vector();
   endtask

   task automatic test_special_cases();
      set_map_size(3, 2);
      send_elem(sbmu_pkg::REQ_LOAD, 0, 0, 16'sh7FFF, 1'b0);
      send_elem(sbmu_pkg::REQ_LOAD, 0, 1, 16'sh8000, 1'b0);
      // last on a load starts nothing
      send_elem(sbmu_pkg::REQ_LOAD, 1, 0, 16'sh8000, 1'b1);
      send_elem(sbmu_pkg::REQ_LOAD, 1, 1, 16'sh7FFF, 1'b0);
      send_elem(sbmu_pkg::REQ_LOAD, 2, 0, 16'sh8000, 1'b0);
      send_elem(sbmu_pkg::REQ_LOAD, 2, 1, 16'sh7FFF, 1'b0);
      // exact match of cells 1 and 2, tie to the lower index
      send_elem(sbmu_pkg::REQ_QUERY, 63, 0, 16'sh8000, 1'b0);
      send_elem(sbmu_pkg::REQ_QUERY, 63, 1, 16'sh7FFF, 1'b1);
      // cells 0, 1 and 2 tie at one full-scale difference each, cell 0 wins
      send_elem(sbmu_pkg::REQ_QUERY, 0, 1, 16'sh8000, 1'b1);
      // no cells searched
      set_map_size(0, 2);
      send_elem(sbmu_pkg::REQ_QUERY, 5, 0, 16'sh1234, 1'b1);
      // no dimensions used, cell 0 wins
      set_map_size(3, 0);
      send_elem(sbmu_pkg::REQ_QUERY, 0, 1, 16'sh0000, 1'b1);
      // oversized registers clamp to the map size
      set_map_size(127, 31);
      send_elem(sbmu_pkg::REQ_QUERY, 0, 15, 16'sh7FFF, 1'b1);
      set_map_size(100, 17);
      send_elem(sbmu_pkg::REQ_QUERY, 21, 3, 16'sh8001, 1'b1);
      // smallest map
      set_map_size(1, 1);
      send_elem(sbmu_pkg::REQ_QUERY, 42, 0, 16'sh0001, 1'b1);
      // largest map, last cell and dim
      set_map_size(64, 16);
      send_elem(sbmu_pkg::REQ_LOAD, 63, 15, 16'sh8000, 1'b1);
      send_elem(sbmu_pkg::REQ_QUERY, 63, 15, 16'sh7FFF, 1'b1);
   endtask

   // receiver stops for a long stretch while the sender keeps pushing
   task automatic test_backpressure();
      set_map_size(4, 2);
      req_steady = 1'b1;
      rsp_hold_left = 400;
      repeat (12) send_query_vector();
      repeat (6) send_elem(sbmu_pkg::REQ_LOAD,
                           sbmu_pkg::CELL_IDX_W'($urandom_range(0, 3)),
                           sbmu_pkg::DIM_IDX_W'($urandom_range(0, 1)),
                           pick_elem(), 1'b0);
      repeat (4) send_query_vector();
      req_steady = 1'b0;
   endtask

   // mostly well-formed queries with random content, plus loads and noise
   task automatic test_random_traffic();
      int phase;
      int start_count;
      int phase_end;
      int pick;
      int ncells;
      int ndims;
      int n;
      phase = 0;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if (phase == 4)
            set_map_size(64, 16);
         else if (phase == 8)
            set_map_size(64, 1);
         else if (phase == 10)
            set_map_size(1, 16);
         else if ($urandom_range(0, 3) == 0)
            set_map_size($urandom_range(1, 64), $urandom_range(1, 16));
         else
            set_map_size($urandom_range(1, 8), $urandom_range(1, 4));
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         ncells = cells_reg;
         ndims  = dims_reg;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               send_query_vector();
            end else if (pick < 8) begin
               n = $urandom_range(1, 4);
               repeat (n)
                  send_elem(sbmu_pkg::REQ_LOAD,
                            sbmu_pkg::CELL_IDX_W'(($urandom_range(0, 3) != 0) ?
                                                  $urandom_range(0, ncells - 1) :
                                                  $urandom_range(0, 63)),
                            sbmu_pkg::DIM_IDX_W'(($urandom_range(0, 3) != 0) ?
                                                 $urandom_range(0, ndims - 1) :
                                                 $urandom_range(0, 15)),
                            pick_elem(), 1'($urandom_range(0, 1)));
            end else begin
               // partial vector without last
               n = $urandom_range(1, ndims);
               repeat (n)
                  send_elem(sbmu_pkg::REQ_QUERY,
                            sbmu_pkg::CELL_IDX_W'($urandom_range(0, 63)),
                            sbmu_pkg::DIM_IDX_W'($urandom_range(0, 15)),
                            pick_elem(), 1'b0);
            end
         end
         phase++;
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // result sink: random stall after each beat, long hold-off on request
   initial begin : rsp_sink
      int wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            wait_left = rsp_steady ? 0 : $urandom_range(0, 6);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each result beat with the oldest expected match
   always @(posedge clock) begin : match_check
      bmu_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result beat: label %0d found %0d",
                        rsp_tdata[sbmu_pkg::LABEL_W-1:0], rsp_tuser[0]);
            mismatch_count++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_tdata[sbmu_pkg::LABEL_W-1:0] !== want.label ||
                rsp_tuser[0] !== want.found) begin
               if (mismatch_count < 10)
                  $display("result mismatch: expected label %0d found %0d, got label %0d found %0d",
                           want.label, want.found, rsp_tdata[sbmu_pkg::LABEL_W-1:0],
                           rsp_tuser[0]);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_map();
      test_special_cases();
      test_backpressure();
      test_random_traffic();
      drain_results();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
